[hw/rtl/rmcb_pkg.sv]
// Shared constants, types and channel math for the RGBA mip chain downsampler.
`default_nettype none

package rmcb_pkg;

    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_LEVELS = 13;

    localparam int TEX_W  = 32;
    localparam int LVL_W  = 4;
    localparam int POS_W  = 11;
    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int DIM_W  = CW + 1;
    localparam int SUM_W  = 36;
    localparam int NCELL  = MAX_LEVELS - 1;
    localparam int REG_W  = 13;
    localparam int MIP_W  = 4;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 4;

    typedef struct packed {
        logic             vld;
        logic             done;
        logic [TEX_W-1:0] texel;
    } t_tok;

    typedef struct packed {
        logic             vld;
        logic [LVL_W-1:0] level;
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
        logic [TEX_W-1:0] texel;
        logic             last;
    } t_res;

    typedef struct packed {
        logic [DIM_W-1:0] w0;
        logic [DIM_W-1:0] h0;
        logic [LVL_W-1:0] nlev;
    } t_geom;

    // Row buffer depth of the cell that reduces level s.
    function automatic int ram_depth(input int s);
        int d;
        d = MAX_WIDTH >> (s + 1);
        return (d < 2) ? 2 : d;
    endfunction

    function automatic int ram_aw(input int s);
        return $clog2(ram_depth(s));
    endfunction

    // Four 9-bit channel sums of a horizontal pair.
    function automatic logic [SUM_W-1:0] pair_sum(input logic [TEX_W-1:0] a,
                                                  input logic [TEX_W-1:0] b);
        logic [SUM_W-1:0] r;
        r = '0;
        for (int c = 0; c < 4; c++) begin
            r[9*c +: 9] = {1'b0, a[8*c +: 8]} + {1'b0, b[8*c +: 8]};
        end
        return r;
    endfunction

    // Rounded half-up average of the 2x2 block.
    function automatic logic [TEX_W-1:0] box_avg(input logic [SUM_W-1:0] top,
                                                 input logic [SUM_W-1:0] bot);
        logic [TEX_W-1:0] r;
        logic [10:0]      s;
        r = '0;
        for (int c = 0; c < 4; c++) begin
            s = {2'b00, top[9*c +: 9]} + {2'b00, bot[9*c +: 9]} + 11'd2;
            r[8*c +: 8] = s[9:2];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/rmcb_stream_if.sv]
// Valid/ready stream channels for base texels and produced mip texels.
`default_nettype none

interface rmcb_in_if;
    logic                       valid;
    logic                       ready;
    logic [rmcb_pkg::TEX_W-1:0] texel;

    modport source (output valid, output texel, input ready);
    modport sink   (input valid, input texel, output ready);
endinterface

interface rmcb_out_if;
    logic                       valid;
    logic                       ready;
    logic [rmcb_pkg::LVL_W-1:0] level;
    logic [rmcb_pkg::POS_W-1:0] col;
    logic [rmcb_pkg::POS_W-1:0] row;
    logic [rmcb_pkg::TEX_W-1:0] result_texel;
    logic                       last;

    modport source (output valid, output level, output col, output row,
                    output result_texel, output last, input ready);
    modport sink   (input valid, input level, input col, input row,
                    input result_texel, input last, output ready);
endinterface

`default_nettype wire

[hw/rtl/rmcb_ram.sv]
// Simple dual-port row buffer RAM with registered read.
`default_nettype none

module rmcb_ram #(
    parameter int DEPTH = 2048
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_we,
    input  wire logic [$clog2(DEPTH)-1:0]         i_wa,
    input  wire logic [rmcb_pkg::SUM_W-1:0]       i_wd,
    input  wire logic [$clog2(DEPTH)-1:0]         i_ra,
    output      logic [rmcb_pkg::SUM_W-1:0]       o_rd
);

    logic [rmcb_pkg::SUM_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
        o_rd <= r_mem[i_ra];
    end

endmodule

`default_nettype wire

[hw/rtl/rmcb_cell.sv]
// One reduction cell: tracks position in its level and builds 2x2 averages.
`default_nettype none

module rmcb_cell (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic [rmcb_pkg::LVL_W-1:0] i_lvl,
    input  wire rmcb_pkg::t_geom            i_geom,
    input  wire logic                       i_adv,
    input  wire logic                       i_restart,
    input  wire rmcb_pkg::t_tok             i_tok,
    output      rmcb_pkg::t_tok             o_tok,
    output      rmcb_pkg::t_res             o_res,
    output      logic                       o_wr_en,
    output      logic [rmcb_pkg::POS_W-1:0] o_wr_addr,
    output      logic [rmcb_pkg::SUM_W-1:0] o_wr_data,
    output      logic [rmcb_pkg::POS_W-1:0] o_rd_addr,
    input  wire logic [rmcb_pkg::SUM_W-1:0] i_rd_data
);

    logic [rmcb_pkg::CW-1:0]    r_col;
    logic [rmcb_pkg::CW-1:0]    r_row;
    logic [rmcb_pkg::TEX_W-1:0] r_left;
    rmcb_pkg::t_tok             r_tok;

    logic [rmcb_pkg::DIM_W-1:0] ws, hs, x_nx, y_nx;
    logic [rmcb_pkg::CW-1:0]    wd, hd;
    logic [rmcb_pkg::POS_W-1:0] col_h, row_h;
    logic                       x_last, y_last, lvl_ok, in_rng, live, emit, done_out, is_end;
    logic [rmcb_pkg::SUM_W-1:0] pair;
    logic [rmcb_pkg::TEX_W-1:0] avg;

    assign ws   = i_geom.w0 >> i_lvl;
    assign hs   = i_geom.h0 >> i_lvl;
    assign wd   = ws[rmcb_pkg::DIM_W-1:1];
    assign hd   = hs[rmcb_pkg::DIM_W-1:1];
    assign x_nx = {1'b0, r_col} + rmcb_pkg::DIM_W'(1);
    assign y_nx = {1'b0, r_row} + rmcb_pkg::DIM_W'(1);
    assign x_last = (x_nx >= ws);
    assign y_last = (y_nx >= hs);
    assign col_h  = r_col[rmcb_pkg::CW-1:1];
    assign row_h  = r_row[rmcb_pkg::CW-1:1];

    assign lvl_ok = (({1'b0, i_lvl} + (rmcb_pkg::LVL_W+1)'(1)) < {1'b0, i_geom.nlev});
    // odd last column or row of the source level is dropped
    assign in_rng = ({1'b0, r_col} < {wd, 1'b0}) && ({1'b0, r_row} < {hd, 1'b0});
    assign live   = i_tok.vld && lvl_ok && in_rng;
    assign emit   = live && r_col[0] && r_row[0];

    // end of the base image is seen by the level-0 cell and rides down the chain
    assign done_out = i_tok.done ||
                      ((i_lvl == '0) && i_tok.vld && x_last && y_last);

    assign is_end = (({1'b0, i_lvl} + (rmcb_pkg::LVL_W+1)'(2)) == {1'b0, i_geom.nlev}) &&
                    (({1'b0, col_h} + rmcb_pkg::CW'(1)) == wd) &&
                    (({1'b0, row_h} + rmcb_pkg::CW'(1)) == hd);

    assign pair = rmcb_pkg::pair_sum(r_left, i_tok.texel);
    assign avg  = rmcb_pkg::box_avg(i_rd_data, pair);

    assign o_wr_en   = i_adv && live && r_col[0] && !r_row[0];
    assign o_wr_addr = col_h;
    assign o_wr_data = pair;
    // read address follows the column counter so data is ready for the odd texel
    assign o_rd_addr = col_h;

    assign o_res.vld   = emit;
    assign o_res.level = i_lvl + rmcb_pkg::LVL_W'(1);
    assign o_res.col   = col_h;
    assign o_res.row   = row_h;
    assign o_res.texel = avg;
    assign o_res.last  = is_end;

    assign o_tok = r_tok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_tok.vld  <= 1'b0;
            r_tok.done <= 1'b0;
        end else if (i_restart) begin
            r_col      <= '0;
            r_row      <= '0;
            r_tok.vld  <= 1'b0;
            r_tok.done <= 1'b0;
        end else if (i_adv) begin
            if (done_out) begin
                r_col <= '0;
                r_row <= '0;
            end else if (i_tok.vld) begin
                if (x_last) begin
                    r_col <= '0;
                    r_row <= y_nx[rmcb_pkg::CW-1:0];
                end else begin
                    r_col <= x_nx[rmcb_pkg::CW-1:0];
                end
            end
            r_tok.vld   <= emit;
            r_tok.done  <= done_out;
            r_tok.texel <= avg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && live && !r_col[0]) begin
            r_left <= i_tok.texel;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/rmcb_cfg.sv]
// APB register block and derived level geometry.
`default_nettype none

module rmcb_cfg (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [rmcb_pkg::ADDR_W-1:0] paddr,
    input  wire logic [rmcb_pkg::DATA_W-1:0] pwdata,
    output      logic [rmcb_pkg::DATA_W-1:0] prdata,
    output      logic                        pready,
    output      rmcb_pkg::t_geom             o_geom,
    output      logic                        o_restart
);

    localparam logic [1:0] REG_SRC_WIDTH  = 2'd0;
    localparam logic [1:0] REG_SRC_HEIGHT = 2'd1;
    localparam logic [1:0] REG_MIP_LEVELS = 2'd2;

    logic [rmcb_pkg::REG_W-1:0] r_src_width;
    logic [rmcb_pkg::REG_W-1:0] r_src_height;
    logic [rmcb_pkg::MIP_W-1:0] r_mip_levels;

    logic                       wr;
    logic [1:0]                 idx;
    logic [rmcb_pkg::DIM_W-1:0] w0, h0, m;
    logic [rmcb_pkg::LVL_W-1:0] lg, n_fit, want;

    assign pready    = 1'b1;
    assign wr        = psel && penable && pwrite;
    assign idx       = paddr[rmcb_pkg::ADDR_W-1:2];
    assign o_restart = wr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= rmcb_pkg::REG_W'(4096);
            r_src_height <= rmcb_pkg::REG_W'(4096);
            r_mip_levels <= rmcb_pkg::MIP_W'(13);
        end else if (wr) begin
            case (idx)
                REG_SRC_WIDTH:  r_src_width  <= pwdata[rmcb_pkg::REG_W-1:0];
                REG_SRC_HEIGHT: r_src_height <= pwdata[rmcb_pkg::REG_W-1:0];
                REG_MIP_LEVELS: r_mip_levels <= pwdata[rmcb_pkg::MIP_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_SRC_WIDTH:  prdata = rmcb_pkg::DATA_W'(r_src_width);
            REG_SRC_HEIGHT: prdata = rmcb_pkg::DATA_W'(r_src_height);
            REG_MIP_LEVELS: prdata = rmcb_pkg::DATA_W'(r_mip_levels);
            default:        prdata = '0;
        endcase
    end

    // dimensions saturate to 1..MAX_WIDTH
    always_comb begin
        if (r_src_width == '0) begin
            w0 = rmcb_pkg::DIM_W'(1);
        end else if (32'(r_src_width) > 32'(rmcb_pkg::MAX_WIDTH)) begin
            w0 = rmcb_pkg::DIM_W'(rmcb_pkg::MAX_WIDTH);
        end else begin
            w0 = rmcb_pkg::DIM_W'(r_src_width);
        end
        if (r_src_height == '0) begin
            h0 = rmcb_pkg::DIM_W'(1);
        end else if (32'(r_src_height) > 32'(rmcb_pkg::MAX_WIDTH)) begin
            h0 = rmcb_pkg::DIM_W'(rmcb_pkg::MAX_WIDTH);
        end else begin
            h0 = rmcb_pkg::DIM_W'(r_src_height);
        end
    end

    // level count: floor(log2(min dim)) + 1, capped by the requested count
    assign m = (w0 < h0) ? w0 : h0;

    always_comb begin
        lg = '0;
        for (int k = 1; k < rmcb_pkg::DIM_W; k++) begin
            if ((m >> k) != '0) begin
                lg = lg + rmcb_pkg::LVL_W'(1);
            end
        end
    end

    assign n_fit = lg + rmcb_pkg::LVL_W'(1);

    always_comb begin
        if (r_mip_levels == '0) begin
            want = rmcb_pkg::LVL_W'(1);
        end else if (r_mip_levels > rmcb_pkg::LVL_W'(rmcb_pkg::MAX_LEVELS)) begin
            want = rmcb_pkg::LVL_W'(rmcb_pkg::MAX_LEVELS);
        end else begin
            want = rmcb_pkg::LVL_W'(r_mip_levels);
        end
    end

    assign o_geom.w0   = w0;
    assign o_geom.h0   = h0;
    assign o_geom.nlev = (want < n_fit) ? want : n_fit;

endmodule

`default_nettype wire

[hw/rtl/rgba_mip_chain_box_downsample.sv]
// Top level: texel stream in, chain of reduction cells, two-entry result queue out.
// A level-L texel is built by cell L-1 from a token registered by each earlier cell,
//   then registered in the result queue. Throughput: one texel per cycle, but an input
//   that completes texels holds off the next input while it walks the cell chain.
// A full two-entry result queue freezes the whole chain until a result is taken.
// Reset: position counters cleared, registers to 4096 x 4096 with 13 levels; row buffers
//   are not cleared and no clearing pass runs. Any register write restarts the image.
`default_nettype none

module rgba_mip_chain_box_downsample (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    rmcb_in_if.sink                          i_texel_ch,
    rmcb_out_if.source                       o_result_ch,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [rmcb_pkg::ADDR_W-1:0] paddr,
    input  wire logic [rmcb_pkg::DATA_W-1:0] pwdata,
    output      logic [rmcb_pkg::DATA_W-1:0] prdata,
    output      logic                        pready
);

    rmcb_pkg::t_geom            geom;
    logic                       restart;
    logic                       adv, busy, accept, push, pop;
    rmcb_pkg::t_tok             w_tok [rmcb_pkg::NCELL+1];
    rmcb_pkg::t_res             w_res [rmcb_pkg::NCELL];
    rmcb_pkg::t_res             res_any;
    logic                       w_we  [rmcb_pkg::NCELL];
    logic [rmcb_pkg::POS_W-1:0] w_wa  [rmcb_pkg::NCELL];
    logic [rmcb_pkg::POS_W-1:0] w_ra  [rmcb_pkg::NCELL];
    logic [rmcb_pkg::SUM_W-1:0] w_wd  [rmcb_pkg::NCELL];
    logic [rmcb_pkg::SUM_W-1:0] w_rd  [rmcb_pkg::NCELL];

    rmcb_pkg::t_res             r_q [2];
    logic                       r_wp, r_rp;
    logic [1:0]                 r_cnt;

    rmcb_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_geom    (geom),
        .o_restart (restart)
    );

    // chain moves whenever the result queue has room for one more entry
    assign adv = (r_cnt != 2'd2);

    always_comb begin
        busy = 1'b0;
        for (int g = 1; g <= rmcb_pkg::NCELL; g++) begin
            busy = busy | w_tok[g].vld;
        end
    end

    // one texel in flight past the first cell keeps results in order
    assign i_texel_ch.ready = adv && !busy;
    assign accept           = i_texel_ch.valid && i_texel_ch.ready;

    assign w_tok[0].vld   = accept;
    assign w_tok[0].done  = 1'b0;
    assign w_tok[0].texel = i_texel_ch.texel;

    for (genvar g = 0; g < rmcb_pkg::NCELL; g++) begin : g_cell
        localparam int DEP = rmcb_pkg::ram_depth(g);
        localparam int AW  = rmcb_pkg::ram_aw(g);

        rmcb_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_lvl     (rmcb_pkg::LVL_W'(g)),
            .i_geom    (geom),
            .i_adv     (adv),
            .i_restart (restart),
            .i_tok     (w_tok[g]),
            .o_tok     (w_tok[g+1]),
            .o_res     (w_res[g]),
            .o_wr_en   (w_we[g]),
            .o_wr_addr (w_wa[g]),
            .o_wr_data (w_wd[g]),
            .o_rd_addr (w_ra[g]),
            .i_rd_data (w_rd[g])
        );

        rmcb_ram #(
            .DEPTH (DEP)
        ) u_ram (
            .i_clk (i_clk),
            .i_we  (w_we[g]),
            .i_wa  (w_wa[g][AW-1:0]),
            .i_wd  (w_wd[g]),
            .i_ra  (w_ra[g][AW-1:0]),
            .o_rd  (w_rd[g])
        );
    end

    // at most one cell produces a texel in any cycle
    always_comb begin
        res_any = '0;
        for (int g = 0; g < rmcb_pkg::NCELL; g++) begin
            if (w_res[g].vld) begin
                res_any = res_any | w_res[g];
            end
        end
    end

    assign push = adv && res_any.vld;
    assign pop  = o_result_ch.valid && o_result_ch.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= 2'(r_cnt + {1'b0, push} - {1'b0, pop});
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= res_any;
        end
    end

    assign o_result_ch.valid        = (r_cnt != '0);
    assign o_result_ch.level        = r_q[r_rp].level;
    assign o_result_ch.col          = r_q[r_rp].col;
    assign o_result_ch.row          = r_q[r_rp].row;
    assign o_result_ch.result_texel = r_q[r_rp].texel;
    assign o_result_ch.last         = r_q[r_rp].last;

endmodule

`default_nettype wire
